FILE: rtl/skf_pkg.sv
// Shared widths, constants, state and control types of the scalar Kalman filter.
`timescale 1ns / 1ps
package skf_pkg;

  localparam int VAL_W     = 24;
  localparam int GAIN_W    = 16;
  localparam int MPLR_W    = GAIN_W + 1;
  localparam int PROD_W    = VAL_W + MPLR_W;
  localparam int DIV_STEPS = GAIN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int MUL_CNT_W = $clog2(MPLR_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

  localparam logic [VAL_W-1:0]  PROCESS_NOISE_RST     = 24'd2560;
  localparam logic [VAL_W-1:0]  MEASUREMENT_NOISE_RST = 24'd10240;
  localparam logic [GAIN_W-1:0] GAIN_MAX  = {GAIN_W{1'b1}};
  localparam logic [MPLR_W-1:0] GAIN_ONE  = {1'b1, {GAIN_W{1'b0}}};
  localparam logic [VAL_W-1:0]  VAL_MAX   = {VAL_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } skf_state_t;

  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic mul_start;
    logic update;
    logic out_load;
  } skf_ctl_t;

endpackage

FILE: rtl/skf_div.sv
// Restoring divider, one quotient bit per cycle, for the gain P * 2^16 / (P + R).
`timescale 1ns / 1ps
module skf_div import skf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VAL_W-1:0]   num,
  input  logic [VAL_W:0]     den,
  output logic               done,
  output logic [GAIN_W-1:0]  quo
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W+1:0]     rem_r, rem_nxt;
  logic [VAL_W:0]       den_r, den_nxt;
  logic [GAIN_W-1:0]    quo_r, quo_nxt;
  logic [VAL_W+1:0]     rem_sh;
  logic                 fits;
  logic                 last;

  assign rem_sh = {rem_r[VAL_W:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, den_r};
  assign last   = cnt_r == DIV_CNT_W'(DIV_STEPS - 1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {2'b00, num};
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      // shift in one quotient bit, subtract when the divisor fits
      rem_nxt = fits ? rem_sh - {1'b0, den_r} : rem_sh;
      quo_nxt = {quo_r[GAIN_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/skf_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, 24-bit multiplicand.
`timescale 1ns / 1ps
module skf_mul import skf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VAL_W-1:0]  mcand,
  input  logic [MPLR_W-1:0] mplier,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0]     mcand_r, mcand_nxt;
  logic [VAL_W-1:0]     hi_r, hi_nxt;
  logic [MPLR_W-1:0]    lo_r, lo_nxt;
  logic [VAL_W:0]       sum;
  logic                 last;

  assign sum  = lo_r[0] ? {1'b0, hi_r} + {1'b0, mcand_r} : {1'b0, hi_r};
  assign last = cnt_r == MUL_CNT_W'(MPLR_W - 1);

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      mcand_nxt = mcand;
      hi_nxt    = '0;
      lo_nxt    = mplier;
    end else if (busy_r) begin
      // add on a set bit, then shift the partial product right
      hi_nxt  = sum[VAL_W:1];
      lo_nxt  = {sum[0], lo_r[MPLR_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

FILE: rtl/scalar_kalman_filter_top.sv
// Scalar Kalman filter: each accepted sample passes through the divider start, the serial
// gain divider (one quotient bit per step), the multiplier start and the two serial
// multipliers (one bit per step) that run side by side for the estimate step and the variance
// update, then the state update and the load of the output register. The block works on one
// sample at a time and turns ready for the next as its result is loaded into the output
// register. A finished result waits in the output register while the next sample is already
// accepted; a second finished result stalls the input until the first is taken.
// Configuration writes are taken in any cycle; write them only while no sample is in flight.
// Writes to unknown indexes are dropped.
`timescale 1ns / 1ps
module scalar_kalman_filter_top import skf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VAL_W-1:0]     in_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VAL_W-1:0]     out_estimate,
  output logic [GAIN_W-1:0]    out_gain,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  skf_state_t state_r, state_nxt;
  skf_ctl_t   ctl;

  logic [VAL_W-1:0]  q_r, q_nxt;
  logic [VAL_W-1:0]  r_r, r_nxt;
  logic [VAL_W-1:0]  est_r, est_nxt;
  logic [VAL_W-1:0]  var_r, var_nxt;
  logic [VAL_W-1:0]  dmag_r, dmag_nxt;
  logic              dneg_r, dneg_nxt;
  logic [GAIN_W-1:0] k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_est_r, out_est_nxt;
  logic [GAIN_W-1:0] out_gain_r, out_gain_nxt;

  logic              div_done;
  logic [GAIN_W-1:0] div_quo;
  logic [VAL_W:0]    den;
  logic [GAIN_W-1:0] k_sel;
  logic              mul_a_done, mul_b_done, mul_done;
  logic [PROD_W-1:0] prod_a, prod_b;
  logic [VAL_W-1:0]  step;
  logic [VAL_W:0]    pv;
  logic              out_free;

  assign den      = {1'b0, var_r} + {1'b0, r_r};
  assign out_free = !out_valid_r || out_ready;
  assign mul_done = mul_a_done & mul_b_done;

  // zero denominator gives zero gain; R of zero gives unit gain, held just below one
  always_comb begin
    if (var_r == '0) begin
      k_sel = '0;
    end else if (r_r == '0) begin
      k_sel = GAIN_MAX;
    end else begin
      k_sel = div_quo;
    end
  end

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (var_r),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  skf_mul u_mul_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctl.mul_start),
    .mcand  (dmag_r),
    .mplier ({1'b0, k_sel}),
    .done   (mul_a_done),
    .prod   (prod_a)
  );

  skf_mul u_mul_var (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctl.mul_start),
    .mcand  (var_r),
    .mplier (GAIN_ONE - {1'b0, k_sel}),
    .done   (mul_b_done),
    .prod   (prod_b)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_MUL;
      ST_MUL:  if (mul_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.in_ready  = 1'b1;
        ctl.div_start = in_valid;
      end
      ST_DIV:  ctl.mul_start = div_done;
      ST_MUL:  ctl.update    = mul_done;
      ST_DONE: ctl.out_load  = out_free;
      default: ctl = '0;
    endcase
  end

  assign step = prod_a[VAL_W+GAIN_W-1:GAIN_W];
  assign pv   = {1'b0, prod_b[VAL_W+GAIN_W-1:GAIN_W]} + {1'b0, q_r};

  always_comb begin
    q_nxt         = q_r;
    r_nxt         = r_r;
    est_nxt       = est_r;
    var_nxt       = var_r;
    dmag_nxt      = dmag_r;
    dneg_nxt      = dneg_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_est_nxt   = out_est_r;
    out_gain_nxt  = out_gain_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_PROCESS_NOISE:     q_nxt = cfg_data;
        CFG_MEASUREMENT_NOISE: r_nxt = cfg_data;
        default: ;
      endcase
    end

    if (ctl.div_start) begin
      dneg_nxt = in_sample < est_r;
      dmag_nxt = (in_sample < est_r) ? est_r - in_sample : in_sample - est_r;
    end

    if (ctl.mul_start) k_nxt = k_sel;

    if (ctl.update) begin
      est_nxt = dneg_r ? est_r - step : est_r + step;
      var_nxt = pv[VAL_W] ? VAL_MAX : pv[VAL_W-1:0];
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
      out_est_nxt   = est_r;
      out_gain_nxt  = k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      q_r         <= PROCESS_NOISE_RST;
      r_r         <= MEASUREMENT_NOISE_RST;
      est_r       <= '0;
      var_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      q_r         <= q_nxt;
      r_r         <= r_nxt;
      est_r       <= est_nxt;
      var_r       <= var_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dmag_r     <= dmag_nxt;
    dneg_r     <= dneg_nxt;
    k_r        <= k_nxt;
    out_est_r  <= out_est_nxt;
    out_gain_r <= out_gain_nxt;
  end

  assign in_ready     = ctl.in_ready;
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign out_gain     = out_gain_r;

endmodule

FILE: rtl/skf_checker.sv
// Port-level checks of the scalar Kalman filter, bound to the top level.
`timescale 1ns / 1ps
module skf_checker import skf_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [VAL_W-1:0]     out_estimate,
  input logic [GAIN_W-1:0]    out_gain
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_estimate) && $stable(out_gain))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while one is in flight");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind scalar_kalman_filter_top skf_checker u_skf_checker (.*);

FILE: tb/tb_scalar_kalman_filter_top.sv
// Self-checking testbench for the scalar Kalman filter: directed corners, random tracking, stalls.
`timescale 1ns / 1ps
module tb_scalar_kalman_filter_top;
  import skf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 160;
  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    logic [VAL_W-1:0]  estimate;
    logic [GAIN_W-1:0] gain;
  } kf_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [VAL_W-1:0]     in_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VAL_W-1:0]     out_estimate;
  logic [GAIN_W-1:0]    out_gain;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  // predictor state and its copy of the registers
  logic [VAL_W-1:0] est_track = '0;
  logic [VAL_W-1:0] var_track = '0;
  logic [VAL_W-1:0] noise_q = PROCESS_NOISE_RST;
  logic [VAL_W-1:0] noise_r = MEASUREMENT_NOISE_RST;

  kf_result_t expected_q[$];
  int  mismatch_count = 0;
  int  samples_sent = 0;
  int  results_checked = 0;
  int  reg_writes = 0;
  bit  idle_en = 1'b1;
  int  sink_hold_req = 0;

  scalar_kalman_filter_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_estimate (out_estimate),
    .out_gain     (out_gain),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("timeout: %0d results still pending", expected_q.size());
    $display("tb_scalar_kalman_filter_top: done, errors");
    $finish;
  end

  // One filter update: gain, estimate step toward the sample, variance update.
  function automatic kf_result_t kalman_update(input logic [VAL_W-1:0] smp);
    logic [VAL_W:0]    den;
    logic [63:0]       quo;
    logic [63:0]       stp;
    logic [63:0]       pv;
    logic [GAIN_W-1:0] k;
    kf_result_t        res;
    den = {1'b0, var_track} + {1'b0, noise_r};
    if (den == '0) begin
      k = '0;
    end else begin
      quo = {24'b0, var_track, 16'b0} / {39'b0, den};
      k = (quo > 64'(GAIN_MAX)) ? GAIN_MAX : quo[GAIN_W-1:0];
    end
    if (smp >= est_track) begin
      stp = (64'(k) * 64'(smp - est_track)) >> GAIN_W;
      est_track = est_track + stp[VAL_W-1:0];
    end else begin
      stp = (64'(k) * 64'(est_track - smp)) >> GAIN_W;
      est_track = est_track - stp[VAL_W-1:0];
    end
    pv = (((64'(GAIN_ONE) - 64'(k)) * 64'(var_track)) >> GAIN_W) + 64'(noise_q);
    var_track = (pv > 64'(VAL_MAX)) ? VAL_MAX : pv[VAL_W-1:0];
    res.estimate = est_track;
    res.gain = k;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Watch all three channels on each edge: track register writes, predict, check.
  always @(posedge clk) begin : channel_watch
    kf_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        if (cfg_index == CFG_PROCESS_NOISE) noise_q = cfg_data;
        else if (cfg_index == CFG_MEASUREMENT_NOISE) noise_r = cfg_data;
      end
      if (in_valid && in_ready) expected_q.push_back(kalman_update(in_sample));
      if (out_valid === 1'b1 && out_ready) begin
        results_checked++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result estimate=%h gain=%h",
                                    out_estimate, out_gain));
        end else begin
          want = expected_q.pop_front();
          if (out_estimate !== want.estimate)
            report_mismatch($sformatf("result %0d estimate %h, want %h",
                                      results_checked, out_estimate, want.estimate));
          if (out_gain !== want.gain)
            report_mismatch($sformatf("result %0d gain %h, want %h",
                                      results_checked, out_gain, want.gain));
        end
      end
    end
  end

  // Result sink: random ready bursts, plus a long hold when a test asks for one.
  initial begin : result_sink
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold_req > 0) begin
        n = sink_hold_req;
        sink_hold_req = 0;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        out_ready <= 1'b0;
      end else begin
        n = $urandom_range(1, 6);
        out_ready <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_sample(input logic [VAL_W-1:0] smp);
    int gap;
    if (idle_en && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (!(in_valid && in_ready));
    samples_sent++;
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_noise();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return VAL_MAX;
      2:       return VAL_W'($urandom_range(0, 4095));
      3:       return VAL_W'($urandom_range(256, 65535));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Mostly noisy readings around a target distance, with jumps and extremes.
  function automatic logic [VAL_W-1:0] pick_sample(input logic [VAL_W-1:0] target);
    int unsigned jitter;
    case ($urandom_range(0, 11))
      0:       return VAL_W'($urandom);
      1:       return '0;
      2:       return VAL_MAX;
      default: begin
        jitter = $urandom_range(0, 2048);
        if ($urandom_range(0, 1) == 0)
          return (target > VAL_MAX - VAL_W'(jitter)) ? VAL_MAX : target + VAL_W'(jitter);
        return (target < VAL_W'(jitter)) ? '0 : target - VAL_W'(jitter);
      end
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_sample('0);
    send_sample(VAL_MAX);
    send_sample(24'h00_6400);
    send_sample('0);
    send_sample(24'h80_0000);
    wait_drained();
  endtask

  // With both noise terms at zero the gain pins at full scale, then P collapses
  // to zero and the gain denominator vanishes.
  task automatic test_zero_denominator_and_unit_gain();
    write_reg(CFG_PROCESS_NOISE, '0);
    write_reg(CFG_MEASUREMENT_NOISE, '0);
    send_sample(VAL_MAX);
    send_sample('0);
    send_sample(24'h12_3456);
    send_sample(VAL_MAX);
    wait_drained();
    write_reg(CFG_PROCESS_NOISE, 24'd10);
    send_sample(24'h00_0100);
    send_sample(24'hFE_DCBA);
    wait_drained();
  endtask

  task automatic test_variance_saturation();
    write_reg(CFG_PROCESS_NOISE, VAL_MAX);
    write_reg(CFG_MEASUREMENT_NOISE, VAL_MAX);
    send_sample('0);
    send_sample(VAL_MAX);
    send_sample('0);
    send_sample(24'h55_AA55);
    send_sample(VAL_MAX);
    wait_drained();
  endtask

  // Spare indexes must leave both registers untouched.
  task automatic test_register_map();
    write_reg(CFG_PROCESS_NOISE, PROCESS_NOISE_RST);
    write_reg(CFG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RST);
    write_reg(CFG_SPARE_2, VAL_MAX);
    write_reg(CFG_SPARE_3, '0);
    send_sample(24'h00_3200);
    send_sample(24'h00_3300);
    send_sample(24'hAA_55AA);
    send_sample(24'h00_3100);
    wait_drained();
  endtask

  task automatic test_random_tracking(input int phases, input int per_phase);
    logic [VAL_W-1:0] target;
    for (int p = 0; p < phases; p++) begin
      wait_drained();
      write_reg(CFG_PROCESS_NOISE, pick_noise());
      write_reg(CFG_MEASUREMENT_NOISE, pick_noise());
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, VAL_W'($urandom));
      target = VAL_W'($urandom);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 19) == 0) target = VAL_W'($urandom);
        send_sample(pick_sample(target));
      end
    end
    wait_drained();
  endtask

  // Hold the sink off while samples keep coming, so the block backs up its input.
  task automatic test_output_backpressure();
    logic [VAL_W-1:0] target;
    target = VAL_W'($urandom);
    idle_en = 1'b0;
    sink_hold_req = LONG_HOLD_CYCLES;
    for (int i = 0; i < 12; i++) send_sample(pick_sample(target));
    wait_drained();
    idle_en = 1'b1;
    for (int i = 0; i < 6; i++) send_sample(pick_sample(target));
    wait_drained();
  endtask

  task automatic test_full_rate(input int count);
    logic [VAL_W-1:0] target;
    idle_en = 1'b0;
    write_reg(CFG_PROCESS_NOISE, PROCESS_NOISE_RST);
    write_reg(CFG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RST);
    target = VAL_W'($urandom);
    for (int i = 0; i < count; i++) send_sample(pick_sample(target));
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_denominator_and_unit_gain();
    test_variance_saturation();
    test_register_map();
    test_random_tracking(6, 60);
    test_output_backpressure();
    test_full_rate(150);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d samples, %0d results checked, %0d register writes",
             samples_sent, results_checked, reg_writes);
    $display("corner gains, saturated variance, spare indexes, long sink hold; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("tb_scalar_kalman_filter_top: done, clean");
    end else begin
      $display("tb_scalar_kalman_filter_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/skf_pkg.sv
rtl/skf_div.sv
rtl/skf_mul.sv
rtl/scalar_kalman_filter_top.sv
rtl/skf_checker.sv
tb/tb_scalar_kalman_filter_top.sv
